// ----- src/deq_pkg.sv -----
// Shared constants, codes and types for the double-ended queue.
package deq_pkg;

  localparam int DATA_W    = 32;
  localparam int REQ_W     = 3;
  localparam int CNT_OUT_W = 5;
  localparam int STAT_W    = 2;
  localparam int DEPTH_DEF = 16;

  // Request codes; codes above REQ_STATUS behave as status only
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_STATUS     = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_FETCH = 3'b100
  } state_t;

  // Slot RAM strobes
  typedef struct packed {
    logic wr_en;
    logic rd_a_en;
    logic rd_b_en;
  } ram_ctl_t;

endpackage

// ----- src/deq_in_if.sv -----
// Request channel interface: valid/ready plus request payload.
interface deq_in_if;
  import deq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

// ----- src/deq_out_if.sv -----
// Result channel interface: valid/ready plus result payload.
interface deq_out_if;
  import deq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;
  logic [CNT_OUT_W-1:0]     entry_count;
  logic [STAT_W-1:0]        status;

  modport source (output valid, popped_value, front_value, back_value, entry_count, status,
                  input ready);
  modport sink   (input valid, popped_value, front_value, back_value, entry_count, status,
                  output ready);
endinterface

// ----- src/deq_slot_ram.sv -----
// Slot RAM: one write port, two registered read ports with enables.
module deq_slot_ram #(
  parameter  int DEPTH = deq_pkg::DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                             clk,
  input  deq_pkg::ram_ctl_t                ctl,
  input  logic [IDX_W-1:0]                 wr_addr,
  input  logic [deq_pkg::DATA_W-1:0]       wr_data,
  input  logic [IDX_W-1:0]                 rd_a_addr,
  input  logic [IDX_W-1:0]                 rd_b_addr,
  output logic [deq_pkg::DATA_W-1:0]       rd_a_data,
  output logic [deq_pkg::DATA_W-1:0]       rd_b_data
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
    if (ctl.rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

// ----- src/double_ended_queue_top.sv -----
// Top level of the double-ended queue: sequencer, ring pointers and result register.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+-----------------------------------------------
//   in_chan   | in  | valid / ready | req_type[2:0], push_value[31:0]
//   out_chan  | out | valid / ready | popped_value, front_value, back_value,
//             |     |               | entry_count[4:0], status[1:0]
//
// Each transaction runs through the steps accept (read the word a pop would remove),
// execute (ring update, write, read the new end words), fetch (load result).
// The steps follow from the registered read ports of the slot RAM, met twice.
// Synchronous active-low reset empties the queue; the RAM is not cleared.
// A held result stalls the fetch step, and no new request is taken until fetch moves on.
module double_ended_queue_top #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_chan,
  deq_out_if.source out_chan
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

  // (base + off) mod DEPTH; base below DEPTH, off at most DEPTH, so one compare/subtract suffices
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [SUM_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + off;
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [REQ_W-1:0]  req_r;
  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] popped_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              fwd_front_r, fwd_back_r;
  logic              pop_ok;

  // Result register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_popped_r, out_front_r, out_back_r;
  logic [CNT_W-1:0]  out_occ_r;
  logic [STAT_W-1:0] out_status_r;

  // RAM hookup
  ram_ctl_t          ram_ctl;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr, rd_a_addr, rd_b_addr;
  logic [DATA_W-1:0] rd_a_data, rd_b_data;

  logic              in_fire;
  logic              out_free;
  logic [IDX_W-1:0]  back_idx;
  logic [IDX_W-1:0]  tail_idx;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  // End positions of the current ring
  assign back_idx = ring_add(front_r, SUM_W'(occ_r) - SUM_W'(1));
  assign tail_idx = ring_add(front_r, SUM_W'(occ_r));

  // Execute step: pointer update and write decision
  always_comb begin
    front_nxt  = front_r;
    occ_nxt    = occ_r;
    status_nxt = STAT_OK;
    pop_ok     = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = tail_idx;
    case (req_r)
      REQ_PUSH_BACK: begin
        if (occ_r == DEPTH_CNT) begin
          status_nxt = STAT_FULL;
        end else begin
          wr_en   = 1'b1;
          occ_nxt = occ_r + CNT_W'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        if (occ_r == DEPTH_CNT) begin
          status_nxt = STAT_FULL;
        end else begin
          front_nxt = (front_r == '0) ? IDX_LAST : front_r - IDX_W'(1);
          wr_addr   = front_nxt;
          wr_en     = 1'b1;
          occ_nxt   = occ_r + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (occ_r == '0) begin
          status_nxt = STAT_EMPTY;
        end else begin
          pop_ok    = 1'b1;
          front_nxt = (front_r == IDX_LAST) ? '0 : front_r + IDX_W'(1);
          occ_nxt   = occ_r - CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (occ_r == '0) begin
          status_nxt = STAT_EMPTY;
        end else begin
          pop_ok  = 1'b1;
          occ_nxt = occ_r - CNT_W'(1);
        end
      end
      REQ_CLEAR: begin
        front_nxt = '0;
        occ_nxt   = '0;
      end
      default: begin
      end
    endcase
    if (state_r != ST_EXEC) begin
      wr_en = 1'b0;
    end
  end

  // Port A: popped word on accept, new front on execute. Port B: new back.
  always_comb begin
    ram_ctl.wr_en   = wr_en;
    ram_ctl.rd_a_en = in_fire || (state_r == ST_EXEC);
    ram_ctl.rd_b_en = (state_r == ST_EXEC);
    rd_a_addr       = front_nxt;
    rd_b_addr       = ring_add(front_nxt, SUM_W'(occ_nxt) - SUM_W'(1));
    if (state_r == ST_IDLE) begin
      rd_a_addr = (in_chan.req_type == REQ_POP_BACK) ? back_idx : front_r;
    end
  end

  deq_slot_ram #(.DEPTH(DEPTH)) u_slot_ram (
    .clk       (clk),
    .ctl       (ram_ctl),
    .wr_addr   (wr_addr),
    .wr_data   (val_r),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_FETCH;
      ST_FETCH: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EXEC) begin
        front_r <= front_nxt;
        occ_r   <= occ_nxt;
      end
      if (state_r == ST_FETCH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload; forwarding covers a push that lands on an end word being read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_chan.req_type;
      val_r <= in_chan.push_value;
    end
    if (state_r == ST_EXEC) begin
      popped_r    <= pop_ok ? rd_a_data : '0;
      status_r    <= status_nxt;
      fwd_front_r <= wr_en && (wr_addr == rd_a_addr);
      fwd_back_r  <= wr_en && (wr_addr == rd_b_addr);
    end
    if (state_r == ST_FETCH && out_free) begin
      out_popped_r <= popped_r;
      out_front_r  <= (occ_r == '0) ? '0 : (fwd_front_r ? val_r : rd_a_data);
      out_back_r   <= (occ_r == '0) ? '0 : (fwd_back_r ? val_r : rd_b_data);
      out_occ_r    <= occ_r;
      out_status_r <= status_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.popped_value = out_popped_r;
  assign out_chan.front_value  = out_front_r;
  assign out_chan.back_value   = out_back_r;
  assign out_chan.entry_count  = CNT_OUT_W'(out_occ_r);
  assign out_chan.status       = out_status_r;

endmodule
